FILE: rtl/gbts_pkg.sv
// Shared types and constants of the gap buffer text store.
// Used by gbts_ram, gbts_engine and gap_buffer_text_store; depends on nothing.
package gbts_pkg;

  localparam int BUF_BYTES   = 1024;
  localparam int ADDR_W      = $clog2(BUF_BYTES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_MOVE   = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [CNT_W-1:0]   position;
    logic [BYTE_W-1:0]  data_byte;
    logic [CNT_W-1:0]   length;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    status_e            status;
    logic [CNT_W-1:0]   text_length;
    logic [CNT_W-1:0]   gap_position;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: rtl/gbts_ram.sv
// Byte store of the gap buffer: one write port, one read port, registered read.
// Depends on gbts_pkg for the depth and the request struct.
module gbts_ram (
  input  logic                     clk_i,
  input  gbts_pkg::mem_req_t       req_i,
  output logic [gbts_pkg::BYTE_W-1:0] rdata_o
);

  logic [gbts_pkg::BYTE_W-1:0] mem_q [gbts_pkg::BUF_BYTES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

FILE: rtl/gbts_engine.sv
// Operation sequencer of the gap buffer: gap registers, byte-wise gap shift,
// insert, delete, move and read. Depends on gbts_pkg; drives the gbts_ram port.
module gbts_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  gbts_pkg::cmd_t              cmd_i,
  output logic                        cmd_ready_o,
  output logic                        res_valid_o,
  output gbts_pkg::res_t              res_o,
  input  logic                        res_ready_i,
  output gbts_pkg::mem_req_t          mem_req_o,
  input  logic [gbts_pkg::BYTE_W-1:0] mem_rdata_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SHIFT  = 5'b00010,
    ST_FINISH = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  localparam logic [gbts_pkg::CNT_W-1:0] BufLen = gbts_pkg::CNT_W'(gbts_pkg::BUF_BYTES);
  localparam logic [gbts_pkg::CNT_W-1:0] One    = gbts_pkg::CNT_W'(1);

  state_e                          state_q, state_d;
  logic [gbts_pkg::CNT_W-1:0]      gs_q, gs_d;
  logic [gbts_pkg::CNT_W-1:0]      gl_q, gl_d;
  logic [gbts_pkg::CNT_W-1:0]      tgt_q, tgt_d;
  logic [gbts_pkg::CNT_W-1:0]      len_q, len_d;
  gbts_pkg::kind_e                 kind_q, kind_d;
  logic [gbts_pkg::BYTE_W-1:0]     data_q, data_d;
  logic [gbts_pkg::BYTE_W-1:0]     rbyte_q, rbyte_d;
  gbts_pkg::status_e               status_q, status_d;
  logic                            pend_q, pend_d;
  logic [gbts_pkg::ADDR_W-1:0]     pend_addr_q, pend_addr_d;

  logic [gbts_pkg::CNT_W-1:0]      tlen, rem, gs_dec, left_dst, right_src, phys;

  always_comb begin
    tlen      = BufLen - gl_q;
    rem       = tlen - cmd_i.position;
    gs_dec    = gs_q - One;
    left_dst  = gs_dec + gl_q;
    right_src = gs_q + gl_q;
    phys      = (cmd_i.position < gs_q) ? cmd_i.position : cmd_i.position + gl_q;
  end

  always_comb begin
    state_d     = state_q;
    gs_d        = gs_q;
    gl_d        = gl_q;
    tgt_d       = tgt_q;
    len_d       = len_q;
    kind_d      = kind_q;
    data_d      = data_q;
    rbyte_d     = rbyte_q;
    status_d    = status_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          kind_d   = cmd_i.kind;
          data_d   = cmd_i.data_byte;
          tgt_d    = cmd_i.position;
          len_d    = '0;
          rbyte_d  = '0;
          status_d = gbts_pkg::STATUS_DONE;
          unique case (cmd_i.kind)
            gbts_pkg::KIND_INSERT: begin
              if (cmd_i.position > tlen) begin
                status_d = gbts_pkg::STATUS_RANGE;
                state_d  = ST_RESP;
              end else if (gl_q == '0) begin
                status_d = gbts_pkg::STATUS_FULL;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_SHIFT;
              end
            end
            gbts_pkg::KIND_DELETE: begin
              if (cmd_i.position >= tlen) begin
                status_d = gbts_pkg::STATUS_RANGE;
                state_d  = ST_RESP;
              end else begin
                len_d   = (cmd_i.length > rem) ? rem : cmd_i.length;
                state_d = ST_SHIFT;
              end
            end
            gbts_pkg::KIND_MOVE: begin
              if (cmd_i.position > tlen) begin
                status_d = gbts_pkg::STATUS_RANGE;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_SHIFT;
              end
            end
            gbts_pkg::KIND_READ: begin
              if (cmd_i.position >= tlen) begin
                status_d = gbts_pkg::STATUS_RANGE;
                state_d  = ST_RESP;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = phys[gbts_pkg::ADDR_W-1:0];
                state_d         = ST_RDWAIT;
              end
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // The byte read last cycle lands on the other side of the gap.
        if (pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pend_addr_q;
          mem_req_o.wdata = mem_rdata_i;
        end
        if (gs_q == tgt_q) begin
          state_d = ST_FINISH;
        end else if (tgt_q < gs_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = gs_dec[gbts_pkg::ADDR_W-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = left_dst[gbts_pkg::ADDR_W-1:0];
          gs_d            = gs_dec;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = right_src[gbts_pkg::ADDR_W-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = gs_q[gbts_pkg::ADDR_W-1:0];
          gs_d            = gs_q + One;
        end
      end

      ST_FINISH: begin
        if (kind_q == gbts_pkg::KIND_INSERT) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = gs_q[gbts_pkg::ADDR_W-1:0];
          mem_req_o.wdata = data_q;
          gs_d            = gs_q + One;
          gl_d            = gl_q - One;
        end else if (kind_q == gbts_pkg::KIND_DELETE) begin
          gl_d = gl_q + len_q;
        end
        state_d = ST_RESP;
      end

      ST_RDWAIT: begin
        rbyte_d = mem_rdata_i;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gs_q    <= '0;
      gl_q    <= BufLen;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      gs_q    <= gs_d;
      gl_q    <= gl_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    len_q       <= len_d;
    kind_q      <= kind_d;
    data_q      <= data_d;
    rbyte_q     <= rbyte_d;
    status_q    <= status_d;
    pend_addr_q <= pend_addr_d;
  end

  assign cmd_ready_o        = (state_q == ST_IDLE);
  assign res_o.read_byte    = rbyte_q;
  assign res_o.status       = status_q;
  assign res_o.text_length  = tlen;
  assign res_o.gap_position = gs_q;

endmodule

FILE: rtl/gap_buffer_text_store.sv
// Top level of the gap buffer text store: stream ports, output word register,
// engine and byte store. Depends on gbts_pkg, gbts_ram and gbts_engine.
//
//  channel  | direction | tdata (low bit up)                       | tuser
//  s_axis   | in        | position 11, data_byte 8, length 11, 0s  | kind 2
//  m_axis   | out       | read_byte 8, text_length 11, gap_pos 11  | status 2
//
// One word is worked on at a time. A read passes a read wait state and the
// result state; a rejected word goes straight to the result state. Insert,
// delete and move pass the shift, finish and result states; the shift copies
// one byte per cycle through the single read and single write port of the byte
// store, as far as the gap travels. The next word is taken once the engine is
// back in idle after a result is registered. Reset clears the gap to cover
// the whole store; the store itself is not cleared, so no clearing pass runs.
// A finished result waits in the output register while the next word is
// accepted; the engine stalls only if it finishes again before that result
// is taken.
module gap_buffer_text_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // position [10:0], data_byte [18:11], length [29:19], zero [31:30]
  input  logic [gbts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind [1:0]
  input  logic [gbts_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_byte [7:0], text_length [18:8], gap_position [29:19], zero [31:30]
  output logic [gbts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status [1:0]
  output logic [gbts_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int PosLo  = 0;
  localparam int DataLo = PosLo + gbts_pkg::CNT_W;
  localparam int LenLo  = DataLo + gbts_pkg::BYTE_W;
  localparam int TlLo   = gbts_pkg::BYTE_W;
  localparam int GpLo   = TlLo + gbts_pkg::CNT_W;
  localparam int OutPad = gbts_pkg::OUT_TDATA_W - GpLo - gbts_pkg::CNT_W;

  gbts_pkg::cmd_t                 cmd;
  gbts_pkg::res_t                 res;
  gbts_pkg::res_t                 out_q, out_d;
  gbts_pkg::mem_req_t             mem_req;
  logic [gbts_pkg::BYTE_W-1:0]    mem_rdata;
  logic                           res_valid, res_ready;
  logic                           out_valid_q, out_valid_d;

  // Unpack the incoming word.
  always_comb begin
    cmd.kind      = gbts_pkg::kind_e'(s_axis_tuser);
    cmd.position  = s_axis_tdata[PosLo +: gbts_pkg::CNT_W];
    cmd.data_byte = s_axis_tdata[DataLo +: gbts_pkg::BYTE_W];
    cmd.length    = s_axis_tdata[LenLo +: gbts_pkg::CNT_W];
  end

  gbts_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_i       (cmd),
    .cmd_ready_o (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  gbts_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result whenever it is empty or its
  // current word leaves in the same cycle.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{OutPad{1'b0}}, out_q.gap_position, out_q.text_length,
                          out_q.read_byte};

  // The gap always lies inside the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.gap_position <= res.text_length)
    else $error("gap start beyond text end");

  // A full-buffer rejection is only reported when the text fills the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == gbts_pkg::STATUS_FULL) |->
      (m_axis_tdata[GpLo-1:TlLo] == gbts_pkg::CNT_W'(gbts_pkg::BUF_BYTES)))
    else $error("full status with free space");

  // Rejected words never carry a read byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != gbts_pkg::STATUS_DONE) |->
      (m_axis_tdata[TlLo-1:0] == '0))
    else $error("read byte on rejected word");

  // An accepted word is never taken while a result is still being handed over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !res_valid)
    else $error("engine accepted a word while busy");

endmodule

FILE: tb/sv/tb_gap_buffer_text_store.sv
// Self-checking testbench of gap_buffer_text_store: directed edge cases, then
// random edit sessions that fill, drain and churn the text under random stalls.
// Depends on gbts_pkg and the RTL of gap_buffer_text_store.
module tb_gap_buffer_text_store;
  import gbts_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1700;
  localparam longint unsigned LIMIT_CYCLES = 64'd3000 * (BUF_BYTES + 32) * 3;

  typedef enum {LOAD_GROW, LOAD_SHRINK, LOAD_CHURN} load_e;

  // Mirror of the text store: predicts one reply per accepted word and keeps
  // the replies that are still on their way.
  class gap_text_scoreboard;
    logic [BYTE_W-1:0] store [BUF_BYTES];
    logic [CNT_W-1:0]  gap_head;
    logic [CNT_W-1:0]  gap_len;
    res_t              replies_due [$];
    int unsigned       mismatches;
    int unsigned       replies_seen;

    function new();
      gap_head     = '0;
      gap_len      = CNT_W'(BUF_BYTES);
      mismatches   = 0;
      replies_seen = 0;
    endfunction

    function int unsigned text_len();
      return BUF_BYTES - int'(gap_len);
    endfunction

    // Slide the gap to a new logical offset, copying the bytes it passes.
    function void move_gap(int dest);
      int gs;
      int gl;
      gs = int'(gap_head);
      gl = int'(gap_len);
      if (dest < gs) begin
        for (int i = gs - dest - 1; i >= 0; i--) store[dest + gl + i] = store[dest + i];
      end else begin
        for (int i = 0; i < dest - gs; i++) store[gs + i] = store[gs + gl + i];
      end
      gap_head = CNT_W'(dest);
    endfunction

    function res_t apply_edit(cmd_t word);
      res_t reply;
      int   tlen;
      int   pos;
      int   run;
      tlen = int'(text_len());
      pos  = int'(word.position);
      run  = int'(word.length);
      reply.read_byte = '0;
      reply.status    = STATUS_DONE;
      case (word.kind)
        KIND_INSERT: begin
          // The range check wins over the full check.
          if (pos > tlen) begin
            reply.status = STATUS_RANGE;
          end else if (gap_len == 0) begin
            reply.status = STATUS_FULL;
          end else begin
            move_gap(pos);
            store[gap_head] = word.data_byte;
            gap_head++;
            gap_len--;
          end
        end
        KIND_DELETE: begin
          if (pos >= tlen) begin
            reply.status = STATUS_RANGE;
          end else begin
            if (run > tlen - pos) run = tlen - pos;
            move_gap(pos);
            gap_len = CNT_W'(int'(gap_len) + run);
          end
        end
        KIND_MOVE: begin
          if (pos > tlen) reply.status = STATUS_RANGE;
          else move_gap(pos);
        end
        default: begin
          if (pos >= tlen) reply.status = STATUS_RANGE;
          else reply.read_byte = store[(pos < int'(gap_head)) ? pos : pos + int'(gap_len)];
        end
      endcase
      reply.text_length  = CNT_W'(text_len());
      reply.gap_position = gap_head;
      return reply;
    endfunction

    function void note_word(cmd_t word);
      replies_due.push_back(apply_edit(word));
    endfunction

    task report(string what);
      if (mismatches < 50) $display("[%0t] reply %0d: %s", $time, replies_seen, what);
      mismatches++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_reply(res_t got);
      res_t want;
      if (replies_due.size() == 0) begin
        report("reply arrived with no word outstanding");
      end else begin
        want = replies_due.pop_front();
        compare_field("read_byte", got.read_byte, want.read_byte);
        compare_field("status", got.status, want.status);
        compare_field("text_length", got.text_length, want.text_length);
        compare_field("gap_position", got.gap_position, want.gap_position);
      end
      replies_seen++;
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  gap_text_scoreboard ledger;
  int unsigned        src_quiet  = 0;
  int unsigned        sink_quiet = 0;
  longint unsigned    cycle_count = 0;

  gap_buffer_text_store uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  // Wait before the next word or reply. Now and then a stretch of back-to-back
  // traffic is drawn so the block also sees full rate on each side.
  function automatic int unsigned draw_wait(inout int unsigned quiet_left);
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 6) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic send_word(input kind_e kind, input int unsigned pos,
                           input int unsigned data, input int unsigned len);
    cmd_t        word;
    int unsigned idle;
    word.kind      = kind;
    word.position  = CNT_W'(pos);
    word.data_byte = BYTE_W'(data);
    word.length    = CNT_W'(len);
    idle = draw_wait(src_quiet);
    @(negedge clk_i);
    if (idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, word.length, word.data_byte, word.position};
    s_axis_tuser  <= word.kind;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    ledger.note_word(word);
  endtask

  // Edit sessions: grow the text until inserts bounce off a full store, drain it
  // with run deletes, then churn a small text. Edits stay near the gap so most
  // gap moves are short; a few jump far. A small share of words is pure noise.
  task automatic run_sessions();
    load_e       phase;
    kind_e       kind;
    int unsigned sent;
    int unsigned full_hits;
    int unsigned tlen;
    int unsigned pos;
    int unsigned len;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned del_pct;
    int unsigned mov_pct;
    phase     = LOAD_GROW;
    sent      = 0;
    full_hits = 0;
    while (sent < RANDOM_WORDS || phase == LOAD_GROW) begin
      tlen = ledger.text_len();
      if (phase == LOAD_GROW && tlen == BUF_BYTES && full_hits >= 6) phase = LOAD_SHRINK;
      else if (phase == LOAD_SHRINK && tlen <= 4) phase = LOAD_CHURN;
      len = $urandom_range(0, 2047);
      if ($urandom_range(0, 99) < 5) begin
        kind = kind_e'($urandom_range(0, 3));
        pos  = $urandom_range(0, 2047);
        // Keep noise from wiping out the text while it is being built up.
        if (phase == LOAD_GROW) len = len % 16;
      end else begin
        case (phase)
          LOAD_GROW:   begin ins_pct = 88; del_pct = 2;  mov_pct = 3;  end
          LOAD_SHRINK: begin ins_pct = 20; del_pct = 45; mov_pct = 10; end
          default:     begin ins_pct = 35; del_pct = 20; mov_pct = 15; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) kind = KIND_INSERT;
        else if (roll < ins_pct + del_pct) kind = KIND_DELETE;
        else if (roll < ins_pct + del_pct + mov_pct) kind = KIND_MOVE;
        else kind = KIND_READ;

        if (kind == KIND_READ || $urandom_range(0, 99) < 4) begin
          pos = $urandom_range(0, tlen);
        end else begin
          pos = ledger.gap_head + $urandom_range(0, 16);
          pos = (pos < 8) ? 0 : pos - 8;
          if (pos > tlen) pos = tlen;
        end

        if (kind == KIND_DELETE) begin
          if (phase == LOAD_GROW) len = $urandom_range(0, 4);
          else if ($urandom_range(0, 99) < 3) len = $urandom_range(0, 2047);
          else if (phase == LOAD_SHRINK) len = $urandom_range(1, 64);
          else len = $urandom_range(0, 8);
        end
        if (kind == KIND_INSERT && tlen == BUF_BYTES) full_hits++;
      end
      send_word(kind, pos, $urandom_range(0, 255), len);
      sent++;
    end
  endtask

  initial begin : reply_sink
    res_t        got;
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(sink_quiet);
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      got.read_byte    = m_axis_tdata[7:0];
      got.text_length  = m_axis_tdata[18:8];
      got.gap_position = m_axis_tdata[29:19];
      got.status       = status_e'(m_axis_tuser);
      ledger.check_reply(got);
    end
  end

  initial begin : stimulus
    ledger        = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty text: reads and deletes at 0, and moves and inserts past the end, are refused; a move to 0 is not.
    send_word(KIND_READ,   0,    8'h00, 0);
    send_word(KIND_DELETE, 0,    8'h00, 5);
    send_word(KIND_MOVE,   0,    8'h00, 0);
    send_word(KIND_MOVE,   1,    8'h00, 0);
    send_word(KIND_INSERT, 1,    8'h11, 0);
    // Build "A5 5A 00 FF" with inserts at the end, the front and the middle.
    send_word(KIND_INSERT, 0,    8'h00, 0);
    send_word(KIND_INSERT, 1,    8'hFF, 0);
    send_word(KIND_INSERT, 0,    8'hA5, 0);
    send_word(KIND_INSERT, 1,    8'h5A, 0);
    send_word(KIND_READ,   0,    8'h00, 2047);
    send_word(KIND_READ,   1,    8'hFF, 0);
    send_word(KIND_READ,   2,    8'h00, 0);
    send_word(KIND_READ,   3,    8'h00, 0);
    send_word(KIND_READ,   4,    8'h00, 0);
    send_word(KIND_READ,   2047, 8'h00, 0);
    send_word(KIND_MOVE,   4,    8'h00, 0);
    send_word(KIND_MOVE,   2047, 8'hFF, 2047);
    // A zero-length delete still moves the gap; an overlong run is clamped.
    send_word(KIND_DELETE, 1,    8'h00, 0);
    send_word(KIND_DELETE, 1,    8'h00, 2047);
    send_word(KIND_DELETE, 1,    8'h00, 1);
    send_word(KIND_INSERT, 2047, 8'hFF, 2047);
    send_word(KIND_INSERT, 1,    8'h3C, 0);
    send_word(KIND_READ,   1,    8'h00, 0);
    send_word(KIND_DELETE, 0,    8'h00, 1024);
    send_word(KIND_READ,   0,    8'h00, 0);

    run_sessions();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (ledger.replies_due.size() != 0) @(posedge clk_i);
    // Any stray reply would have to show up within one full gap shift.
    repeat (BUF_BYTES + 16) @(posedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: gap_buffer_text_store.f
rtl/gbts_pkg.sv
rtl/gbts_ram.sv
rtl/gbts_engine.sv
rtl/gap_buffer_text_store.sv
tb/sv/tb_gap_buffer_text_store.sv
